FILE: sv/ci64_pkg.sv
// types, operation codes and the fast-class result function of the checked 64-bit alu
// used by every module of the block but ci64_fifo; depends on nothing
`timescale 1ns / 1ps

package ci64_pkg;

  localparam int unsigned REQ_DEPTH = 4;
  localparam int unsigned RSP_DEPTH = 2;

  localparam logic [63:0] MIN_S64   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MINUS_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PLUS_ONE  = 64'd1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef enum logic [4:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_MUL    = 5'd2,
    OP_DIV    = 5'd3,
    OP_MOD    = 5'd4,
    OP_DIVMOD = 5'd5,
    OP_CMP    = 5'd6,
    OP_AND    = 5'd7,
    OP_OR     = 5'd8,
    OP_XOR    = 5'd9,
    OP_NOT    = 5'd10,
    OP_SHL    = 5'd11,
    OP_SHR    = 5'd12,
    OP_NEG    = 5'd13,
    OP_ABS    = 5'd14,
    OP_ZERO   = 5'd15,
    OP_POS    = 5'd16,
    OP_NEGT   = 5'd17,
    OP_EVEN   = 5'd18,
    OP_ODD    = 5'd19
  } op_e;

  typedef enum logic [1:0] {
    CLS_FAST = 2'd0,
    CLS_MUL  = 2'd1,
    CLS_DIV  = 2'd2
  } cls_e;

  typedef struct packed {
    logic        [4:0]  req_type;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
    logic        [5:0]  shift_amount;
  } ci64_req_t;

  typedef struct packed {
    logic signed [63:0] value_out;
    logic signed [63:0] remainder_out;
    logic        [1:0]  status;
  } ci64_rsp_t;

  // classified request as it waits between front and back
  typedef struct packed {
    ci64_req_t   req;
    cls_e        cls;
    logic        neg_a;
    logic        neg_b;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
  } ci64_entry_t;

  // result of every operation of the fast class, division errors included
  function automatic ci64_rsp_t fast_result(ci64_entry_t e);
    ci64_rsp_t   r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] s;
    logic [63:0] t;
    r = '0;
    a = e.req.operand_a;
    b = e.req.operand_b;
    s = '0;
    t = '0;
    case (op_e'(e.req.req_type))
      OP_ADD: begin
        s = a + b;
        t = (a ^ s) & (b ^ s);
        if (t[63]) r.status = ST_OVF;
        else r.value_out = s;
      end
      OP_SUB: begin
        s = a - b;
        t = (a ^ b) & (a ^ s);
        if (t[63]) r.status = ST_OVF;
        else r.value_out = s;
      end
      OP_DIV, OP_MOD, OP_DIVMOD: begin
        if (b == '0) r.status = ST_DIV0;
        else if (op_e'(e.req.req_type) != OP_MOD && a == MIN_S64 && b == MINUS_ONE)
          r.status = ST_OVF;
      end
      OP_CMP: begin
        if ((a ^ MIN_S64) < (b ^ MIN_S64)) r.value_out = MINUS_ONE;
        else if ((b ^ MIN_S64) < (a ^ MIN_S64)) r.value_out = PLUS_ONE;
      end
      OP_AND: r.value_out = a & b;
      OP_OR:  r.value_out = a | b;
      OP_XOR: r.value_out = a ^ b;
      OP_NOT: r.value_out = ~a;
      OP_SHL: r.value_out = a << e.req.shift_amount;
      OP_SHR: r.value_out = $signed(a) >>> e.req.shift_amount;
      OP_NEG: begin
        if (a == MIN_S64) r.status = ST_OVF;
        else r.value_out = ~a + PLUS_ONE;
      end
      OP_ABS: begin
        if (a == MIN_S64) r.status = ST_OVF;
        else r.value_out = e.mag_a;
      end
      OP_ZERO: r.value_out = {63'd0, a == '0};
      OP_POS:  r.value_out = {63'd0, !a[63] && a != '0};
      OP_NEGT: r.value_out = {63'd0, a[63]};
      OP_EVEN: r.value_out = {63'd0, !a[0]};
      OP_ODD:  r.value_out = {63'd0, a[0]};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/ci64_fifo.sv
// small synchronous queue of packed beats, register array with wrapping pointers
// depends on nothing
`timescale 1ns / 1ps

module ci64_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + CntW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

FILE: sv/ci64_front.sv
// front end: classifies each request, takes operand magnitudes, queues it for the back end
// depends on ci64_pkg and ci64_fifo
`timescale 1ns / 1ps

module ci64_front
  import ci64_pkg::*;
#(
  parameter int unsigned Depth = REQ_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  ci64_req_t   req_i,
  output logic        issue_valid_o,
  input  logic        issue_take_i,
  output ci64_entry_t issue_o
);

  ci64_entry_t ent;
  logic        wr_ready;
  logic        div_err;
  op_e         op;

  // classify and precompute magnitudes
  always_comb begin
    op      = op_e'(req_i.req_type);
    div_err = (req_i.operand_b == '0) ||
              (op != OP_MOD && req_i.operand_a == MIN_S64 && req_i.operand_b == MINUS_ONE);
    ent.req   = req_i;
    ent.neg_a = req_i.operand_a[63];
    ent.neg_b = req_i.operand_b[63];
    ent.mag_a = req_i.operand_a[63] ? ~req_i.operand_a + PLUS_ONE : req_i.operand_a;
    ent.mag_b = req_i.operand_b[63] ? ~req_i.operand_b + PLUS_ONE : req_i.operand_b;
    case (op)
      OP_MUL:                    ent.cls = CLS_MUL;
      OP_DIV, OP_MOD, OP_DIVMOD: ent.cls = div_err ? CLS_FAST : CLS_DIV;
      default:                   ent.cls = CLS_FAST;
    endcase
  end

  assign full = !wr_ready;

  // queue between front and back
  ci64_fifo #(
    .Depth (Depth),
    .Width ($bits(ci64_entry_t))
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_ready_o (wr_ready),
    .wr_data_i  (ent),
    .rd_valid_o (issue_valid_o),
    .rd_ready_i (issue_take_i),
    .rd_data_o  (issue_o)
  );

endmodule

FILE: sv/ci64_back.sv
// back end: fast ops, multiply by 32-bit partial products,
// restoring divider one bit a cycle; depends on ci64_pkg
`timescale 1ns / 1ps

module ci64_back
  import ci64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        issue_valid_i,
  output logic        issue_take_o,
  input  ci64_entry_t issue_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output ci64_rsp_t   res_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_MFIN = 6'b000100,
    S_DIV  = 6'b001000,
    S_DFIN = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  localparam logic [5:0] MUL_LAST = 6'd4;
  localparam logic [5:0] DIV_LAST = 6'd63;

  state_e       state_q, state_d;
  logic [5:0]   cnt_q, cnt_d;
  op_e          op_q;
  logic         neg_a_q, neg_b_q;
  logic [63:0]  opa_q, opb_q, rem_q, prod_q;
  logic [127:0] acc_q;
  ci64_rsp_t    res_q, mfin_res, dfin_res;

  logic         start_mul, start_div;
  logic [31:0]  xs, ys;
  logic [1:0]   prev_idx;
  logic [127:0] prod_ext;
  logic [63:0]  trial, q_neg, r_neg, lo, hi;
  logic         ge, mneg;

  // control
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    issue_take_o = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = fast_result(issue_i);
    start_mul    = 1'b0;
    start_div    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (issue_valid_i) begin
          unique case (issue_i.cls)
            CLS_MUL: begin
              issue_take_o = 1'b1;
              start_mul    = 1'b1;
              cnt_d        = '0;
              state_d      = S_MUL;
            end
            CLS_DIV: begin
              issue_take_o = 1'b1;
              start_div    = 1'b1;
              cnt_d        = '0;
              state_d      = S_DIV;
            end
            default: begin
              issue_take_o = res_ready_i;
              res_valid_o  = 1'b1;
            end
          endcase
        end
      end
      S_MUL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == MUL_LAST) state_d = S_MFIN;
      end
      S_MFIN: state_d = S_DONE;
      S_DIV: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == DIV_LAST) state_d = S_DFIN;
      end
      S_DFIN: state_d = S_DONE;
      S_DONE: begin
        res_valid_o = 1'b1;
        res_o       = res_q;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // multiply step: partial product select and shifted accumulate
  always_comb begin
    xs       = cnt_q[1] ? opa_q[63:32] : opa_q[31:0];
    ys       = cnt_q[0] ? opb_q[63:32] : opb_q[31:0];
    prev_idx = cnt_q[1:0] - 2'd1;
    case (prev_idx)
      2'd0:    prod_ext = {64'd0, prod_q};
      2'd3:    prod_ext = {prod_q, 64'd0};
      default: prod_ext = {32'd0, prod_q, 32'd0};
    endcase
  end

  // divide step: shift in one dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q[62:0], opa_q[63]};
    ge    = (trial >= opb_q);
  end

  // multiply finish: range check and sign
  always_comb begin
    lo             = acc_q[63:0];
    hi             = acc_q[127:64];
    mneg           = neg_a_q ^ neg_b_q;
    mfin_res       = '0;
    if (hi != '0 || lo > MIN_S64 || (!mneg && lo == MIN_S64)) mfin_res.status = ST_OVF;
    else mfin_res.value_out = mneg ? ~lo + PLUS_ONE : lo;
  end

  // divide finish: signs of quotient and remainder
  always_comb begin
    q_neg    = (neg_a_q ^ neg_b_q) ? ~opa_q + PLUS_ONE : opa_q;
    r_neg    = neg_a_q ? ~rem_q + PLUS_ONE : rem_q;
    dfin_res = '0;
    case (op_q)
      OP_DIV: dfin_res.value_out = q_neg;
      OP_MOD: dfin_res.value_out = r_neg;
      default: begin
        dfin_res.value_out     = q_neg;
        dfin_res.remainder_out = r_neg;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_mul || start_div) begin
      op_q    <= op_e'(issue_i.req.req_type);
      neg_a_q <= issue_i.neg_a;
      neg_b_q <= issue_i.neg_b;
      opa_q   <= issue_i.mag_a;
      opb_q   <= issue_i.mag_b;
      rem_q   <= '0;
      acc_q   <= '0;
    end
    if (state_q == S_MUL) begin
      if (cnt_q != MUL_LAST) prod_q <= xs * ys;
      if (cnt_q != '0) acc_q <= acc_q + prod_ext;
    end
    if (state_q == S_DIV) begin
      rem_q <= ge ? trial - opb_q : trial;
      opa_q <= {opa_q[62:0], ge};
    end
    if (state_q == S_MFIN) res_q <= mfin_res;
    if (state_q == S_DFIN) res_q <= dfin_res;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: sv/checked_int64_alu.sv
// top level of the checked 64-bit signed alu: front end, back end and result queue
// depends on ci64_pkg, ci64_front, ci64_back and ci64_fifo
`timescale 1ns / 1ps

// usage
// - requests enter as beats of ci64_req_t: a beat is taken at a clock edge with push high
//   and full low; full rises only when the request queue holds ReqDepth beats
// - results leave in request order as beats of ci64_rsp_t: rsp_o carries the oldest result
//   while empty is low, and it is taken at an edge with pop high and empty low
// - throughput: all operations but mul, div, mod and divmod (division errors included)
//   finish in the back end's idle state, one beat per cycle while the result queue has room
// - mul holds the back end through a start step, four 32x32 partial products on one
//   multiplier, one more accumulate step, a range check step and a hand-off step
// - div, mod and divmod hold it through a start step, the restoring divider making one
//   quotient bit per cycle, 64 in all, then sign fix-up and hand-off steps
// - a fast op with no stall goes from push to rsp_o through the registered request queue,
//   the back end's idle state and the registered result queue
// - when pop stays low the result queue fills, the back end waits, then the request queue
//   fills and full rises; no beat is lost or repeated
// - reset empties both queues and returns the back end to idle; no clearing pass is needed

module checked_int64_alu
  import ci64_pkg::*;
#(
  parameter int unsigned ReqDepth = REQ_DEPTH,
  parameter int unsigned RspDepth = RSP_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  ci64_req_t req_i,
  output logic      empty,
  input  logic      pop,
  output ci64_rsp_t rsp_o
);

  logic        issue_valid, issue_take;
  ci64_entry_t issue;
  logic        res_valid, res_ready, rsp_valid;
  ci64_rsp_t   res;

  // classify and queue requests
  ci64_front #(
    .Depth (ReqDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_i         (req_i),
    .issue_valid_o (issue_valid),
    .issue_take_i  (issue_take),
    .issue_o       (issue)
  );

  // execute
  ci64_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_valid_i (issue_valid),
    .issue_take_o  (issue_take),
    .issue_i       (issue),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // result queue
  ci64_fifo #(
    .Depth (RspDepth),
    .Width ($bits(ci64_rsp_t))
  ) u_rsp_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_valid),
    .wr_ready_o (res_ready),
    .wr_data_i  (res),
    .rd_valid_o (rsp_valid),
    .rd_ready_i (pop),
    .rd_data_o  (rsp_o)
  );

  assign empty = !rsp_valid;

endmodule

FILE: tb/sv/tb_checked_int64_alu.sv
// self-checking testbench of checked_int64_alu: directed corner operations, then random
// requests with random push and pop gaps; depends on ci64_pkg and the alu rtl
`timescale 1ns / 1ps

module tb_checked_int64_alu;
  import ci64_pkg::*;

  localparam int unsigned NumRandom = 1350;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  ci64_req_t req_i;
  logic      empty;
  logic      pop;
  ci64_rsp_t rsp_o;

  ci64_req_t pending_reqs[$];
  ci64_rsp_t expected_rsps[$];
  int unsigned num_errors;
  int unsigned num_checked;
  int unsigned push_gap;
  int unsigned pop_gap;
  bit          stim_done;

  checked_int64_alu DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .req_i  (req_i),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sign-magnitude helper
  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // predicted result of one request
  function automatic ci64_rsp_t alu_result(ci64_req_t q);
    ci64_rsp_t   r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] s;
    logic [127:0] prod;
    logic [63:0] quo;
    logic [63:0] remd;
    logic        sgn;
    r = '0;
    a = q.operand_a;
    b = q.operand_b;
    case (q.req_type)
      OP_ADD: begin
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) r.status = ST_OVF;
        else r.value_out = s;
      end
      OP_SUB: begin
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) r.status = ST_OVF;
        else r.value_out = s;
      end
      OP_MUL: begin
        sgn = a[63] ^ b[63];
        prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
        if (prod > {64'd0, MIN_S64} || (!sgn && prod == {64'd0, MIN_S64}))
          r.status = ST_OVF;
        else r.value_out = sgn ? (~prod[63:0] + 64'd1) : prod[63:0];
      end
      OP_DIV, OP_MOD, OP_DIVMOD: begin
        if (b == 64'd0) r.status = ST_DIV0;
        else if (q.req_type != OP_MOD && a == MIN_S64 && b == MINUS_ONE)
          r.status = ST_OVF;
        else begin
          quo = abs64(a) / abs64(b);
          remd = abs64(a) % abs64(b);
          if (a[63] != b[63]) quo = ~quo + 64'd1;
          if (a[63]) remd = ~remd + 64'd1;
          if (q.req_type == OP_DIV) r.value_out = quo;
          else if (q.req_type == OP_MOD) r.value_out = remd;
          else begin
            r.value_out = quo;
            r.remainder_out = remd;
          end
        end
      end
      OP_CMP: begin
        if ($signed(a) < $signed(b)) r.value_out = MINUS_ONE;
        else if ($signed(a) > $signed(b)) r.value_out = PLUS_ONE;
      end
      OP_AND: r.value_out = a & b;
      OP_OR:  r.value_out = a | b;
      OP_XOR: r.value_out = a ^ b;
      OP_NOT: r.value_out = ~a;
      OP_SHL: r.value_out = a << q.shift_amount;
      OP_SHR: r.value_out = $signed(a) >>> q.shift_amount;
      OP_NEG: begin
        if (a == MIN_S64) r.status = ST_OVF;
        else r.value_out = ~a + 64'd1;
      end
      OP_ABS: begin
        if (a == MIN_S64) r.status = ST_OVF;
        else r.value_out = abs64(a);
      end
      OP_ZERO: r.value_out = {63'd0, a == 64'd0};
      OP_POS:  r.value_out = {63'd0, !a[63] && a != 64'd0};
      OP_NEGT: r.value_out = {63'd0, a[63]};
      OP_EVEN: r.value_out = {63'd0, !a[0]};
      OP_ODD:  r.value_out = {63'd0, a[0]};
      default: r = '0;
    endcase
    return r;
  endfunction

  // operand picked from corners, small values, random values with all-zero or all-one upper halves, or full random
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN_S64;
      1: return ~MIN_S64;
      2: return MINUS_ONE;
      3: return 64'd0;
      4: return 64'($signed($urandom_range(0, 40)) - 20);
      5: return {{32{1'b0}}, $urandom()};
      6: return {{32{1'b1}}, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // mostly short gaps, a few long ones, stretches of none
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_req(logic [4:0] op, logic [63:0] a, logic [63:0] b, logic [5:0] sh);
    ci64_req_t q;
    q.req_type = op;
    q.operand_a = a;
    q.operand_b = b;
    q.shift_amount = sh;
    pending_reqs.push_back(q);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    num_errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // stimulus
  initial begin
    ci64_req_t q;
    num_errors = 0;
    num_checked = 0;
    stim_done = 1'b0;
    add_req(OP_ADD, ~MIN_S64, 64'd1, 6'd0);
    add_req(OP_ADD, MIN_S64, MINUS_ONE, 6'd63);
    add_req(OP_SUB, MIN_S64, 64'd1, 6'd0);
    add_req(OP_MUL, MIN_S64, 64'd1, 6'd0);
    add_req(OP_MUL, MIN_S64, MINUS_ONE, 6'd0);
    add_req(OP_MUL, 64'h0000_0001_0000_0000, 64'hFFFF_FFFF_8000_0000, 6'd0);
    add_req(OP_DIV, 64'd7, 64'd0, 6'd0);
    add_req(OP_DIV, MIN_S64, MINUS_ONE, 6'd0);
    add_req(OP_MOD, MIN_S64, MINUS_ONE, 6'd0);
    add_req(OP_MOD, 64'd5, 64'd0, 6'd0);
    add_req(OP_DIVMOD, -64'sd7, 64'd2, 6'd0);
    add_req(OP_DIVMOD, MIN_S64, MINUS_ONE, 6'd0);
    add_req(OP_CMP, MIN_S64, ~MIN_S64, 6'd0);
    add_req(OP_CMP, 64'd3, 64'd3, 6'd0);
    add_req(OP_AND, MINUS_ONE, 64'h5555_5555_5555_5555, 6'd0);
    add_req(OP_OR, 64'd0, MIN_S64, 6'd0);
    add_req(OP_XOR, MINUS_ONE, MINUS_ONE, 6'd0);
    add_req(OP_NOT, 64'd0, 64'd0, 6'd0);
    add_req(OP_SHL, MINUS_ONE, 64'd0, 6'd63);
    add_req(OP_SHR, MIN_S64, 64'd0, 6'd63);
    add_req(OP_NEG, MIN_S64, 64'd0, 6'd0);
    add_req(OP_ABS, MIN_S64, 64'd0, 6'd0);
    add_req(OP_ZERO, 64'd0, 64'd0, 6'd0);
    add_req(OP_POS, ~MIN_S64, 64'd0, 6'd0);
    add_req(5'd31, MINUS_ONE, MINUS_ONE, 6'd63);
    for (int i = 0; i < NumRandom; i++) begin
      q.req_type = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 19));
      q.operand_a = pick_operand();
      q.operand_b = pick_operand();
      q.shift_amount = 6'($urandom_range(0, 63));
      pending_reqs.push_back(q);
    end
    stim_done = 1'b1;
  end

  // reset
  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: one request per beat, random gaps between beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      req_i <= '0;
      push_gap <= 0;
    end else begin
      if (push && !full) begin
        expected_rsps.push_back(alu_result(req_i));
      end
      if (push && full) begin
        // hold the offered beat
      end else if (push_gap != 0) begin
        push <= 1'b0;
        push_gap <= push_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        push <= 1'b1;
        req_i <= pending_reqs.pop_front();
        push_gap <= pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: compare each popped result with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    ci64_rsp_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected beat", rsp_o.value_out, 64'd0);
        end else begin
          want = expected_rsps.pop_front();
          num_checked++;
          if (rsp_o.value_out !== want.value_out)
            report_mismatch("value_out", rsp_o.value_out, want.value_out);
          if (rsp_o.remainder_out !== want.remainder_out)
            report_mismatch("remainder_out", rsp_o.remainder_out, want.remainder_out);
          if (rsp_o.status !== want.status)
            report_mismatch("status", 64'(rsp_o.status), 64'(want.status));
        end
      end
      if (pop_gap != 0) begin
        pop <= 1'b0;
        pop_gap <= pop_gap - 1;
      end else begin
        pop <= 1'b1;
        pop_gap <= pick_gap();
      end
    end
  end

  // end of run
  initial begin
    @(posedge rst_ni);
    wait (stim_done && pending_reqs.size() == 0);
    @(posedge clk_i);
    while (push || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("checked %0d results from directed corners and random requests", num_checked);
    if (num_errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
